// ----- rtl/sscr_pkg.sv -----
// Shared types, constants and codes for the serial sensor command responder.
// Used by every module of the block and by the channel interfaces' users.
// No dependencies.
package sscr_pkg;

  // Command line buffer.
  localparam int COMMAND_DEPTH = 10;
  localparam int CNT_W = $clog2(COMMAND_DEPTH + 1);
  localparam int IDX_W = $clog2(COMMAND_DEPTH);

  // Job queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Characters.
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] NO_DIGIT   = 8'h58;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // Recognised command words, first character in the most significant byte.
  localparam logic [31:0] WORD_TEMP = "TEMP";
  localparam logic [23:0] WORD_POT  = "POT";
  localparam logic [55:0] WORD_ON   = "CONT_ON";
  localparam logic [63:0] WORD_OFF  = {"CONT_", "OFF"};
  localparam logic [CNT_W-1:0] LEN_TEMP = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_POT  = CNT_W'(3);
  localparam logic [CNT_W-1:0] LEN_ON   = CNT_W'(7);
  localparam logic [CNT_W-1:0] LEN_OFF  = CNT_W'(8);

  // Reading conversion: value = (sample * 806 + bias) / divisor, one lane per sensor.
  // The division is a multiply by floor(2^32 / divisor) followed by one correction step.
  localparam int LANES     = 2;
  localparam int LANE_TEMP = 0;
  localparam int LANE_POT  = 1;
  localparam logic [9:0]  SCALE = 10'd806;
  localparam logic [12:0] BIAS    [LANES] = '{13'd0, 13'd5000};
  localparam logic [13:0] DIVISOR [LANES] = '{14'd1000, 14'd10000};
  localparam logic [22:0] RECIP   [LANES] = '{23'd4294967, 23'd429496};
  localparam int RECIP_SHIFT = 32;
  localparam logic [9:0] SAT_MAX = 10'd999;

  // Decimal digit split: v / 100 = (v * 41) >> 12 for v < 1000,
  // r / 10 = (r * 103) >> 10 for r < 100.
  localparam logic [5:0] HUND_RECIP = 6'd41;
  localparam int HUND_SHIFT = 12;
  localparam logic [6:0] HUND_BASE = 7'd100;
  localparam logic [6:0] TENS_RECIP = 7'd103;
  localparam int TENS_SHIFT = 10;
  localparam logic [3:0] TENS_BASE = 4'd10;

  typedef logic [0:2][7:0] digits_t;

  typedef enum logic [1:0] {
    JOB_TEMP,
    JOB_POT,
    JOB_TICK
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    digits_t   temp;
    digits_t   volt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                          done;
    logic [0:LANES-1][0:2][3:0]    bcd;
  } conv_res_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_QUOT,
    CV_FIX,
    CV_HUND,
    CV_REM,
    CV_TENS,
    CV_ONES
  } conv_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

// ----- rtl/sscr_in_if.sv -----
// Input channel of the serial sensor command responder: valid, ready and one item.
// No dependencies.
interface sscr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  rx_byte;
  logic        frame_error;
  logic        overrun_error;
  logic [11:0] temp_sample;
  logic [11:0] pot_sample;

  modport source (
    output valid, operation, rx_byte, frame_error, overrun_error, temp_sample, pot_sample,
    input  ready
  );
  modport sink (
    input  valid, operation, rx_byte, frame_error, overrun_error, temp_sample, pot_sample,
    output ready
  );
endinterface

// ----- rtl/sscr_out_if.sv -----
// Output channel of the serial sensor command responder: valid, ready and one reply byte.
// No dependencies.
interface sscr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink (input valid, tx_byte, last, output ready);
endinterface

// ----- rtl/sscr_conv.sv -----
// Sensor reading converter: scales both readings and splits them into decimal digits.
// Multi-cycle sequencer, one multiplication per lane per step. Depends on sscr_pkg.
module sscr_conv (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [11:0]         temp_sample,
  input  logic [11:0]         pot_sample,
  output logic                busy,
  output sscr_pkg::conv_res_t res
);

  sscr_pkg::conv_state_t state, state_next;

  logic [11:0] sample     [sscr_pkg::LANES];
  logic [21:0] acc        [sscr_pkg::LANES];
  logic [11:0] quo        [sscr_pkg::LANES];
  logic [9:0]  val        [sscr_pkg::LANES];
  logic [3:0]  hund       [sscr_pkg::LANES];
  logic [6:0]  rem        [sscr_pkg::LANES];
  logic [3:0]  tens       [sscr_pkg::LANES];
  logic [3:0]  ones       [sscr_pkg::LANES];
  logic [21:0] scale_prod [sscr_pkg::LANES];
  logic [44:0] quot_prod  [sscr_pkg::LANES];
  logic [21:0] fix_prod   [sscr_pkg::LANES];
  logic [21:0] resid      [sscr_pkg::LANES];
  logic [11:0] quo_fixed  [sscr_pkg::LANES];
  logic [15:0] hund_prod  [sscr_pkg::LANES];
  logic [9:0]  rem_prod   [sscr_pkg::LANES];
  logic [13:0] tens_prod  [sscr_pkg::LANES];
  logic [6:0]  ones_prod  [sscr_pkg::LANES];

  // Step sequence register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscr_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Each accepted reading walks through every step once.
  always_comb begin
    state_next = state;
    unique case (state)
      sscr_pkg::CV_IDLE: if (start) state_next = sscr_pkg::CV_QUOT;
      sscr_pkg::CV_QUOT: state_next = sscr_pkg::CV_FIX;
      sscr_pkg::CV_FIX:  state_next = sscr_pkg::CV_HUND;
      sscr_pkg::CV_HUND: state_next = sscr_pkg::CV_REM;
      sscr_pkg::CV_REM:  state_next = sscr_pkg::CV_TENS;
      sscr_pkg::CV_TENS: state_next = sscr_pkg::CV_ONES;
      sscr_pkg::CV_ONES: state_next = sscr_pkg::CV_IDLE;
      default:           state_next = sscr_pkg::CV_IDLE;
    endcase
  end

  assign busy = (state != sscr_pkg::CV_IDLE);

  // Per-lane arithmetic; each step register takes one product.
  always_comb begin
    sample[sscr_pkg::LANE_TEMP] = temp_sample;
    sample[sscr_pkg::LANE_POT]  = pot_sample;
    for (int l = 0; l < sscr_pkg::LANES; l++) begin
      scale_prod[l] = 22'(sample[l]) * 22'(sscr_pkg::SCALE) + 22'(sscr_pkg::BIAS[l]);
      quot_prod[l]  = 45'(acc[l]) * 45'(sscr_pkg::RECIP[l]);
      fix_prod[l]   = 22'(quo[l]) * 22'(sscr_pkg::DIVISOR[l]);
      resid[l]      = acc[l] - fix_prod[l];
      quo_fixed[l]  = quo[l] + 12'(resid[l] >= 22'(sscr_pkg::DIVISOR[l]));
      hund_prod[l]  = 16'(val[l]) * 16'(sscr_pkg::HUND_RECIP);
      rem_prod[l]   = 10'(hund[l]) * 10'(sscr_pkg::HUND_BASE);
      tens_prod[l]  = 14'(rem[l]) * 14'(sscr_pkg::TENS_RECIP);
      ones_prod[l]  = 7'(tens[l]) * 7'(sscr_pkg::TENS_BASE);
      ones[l]       = 4'(rem[l] - ones_prod[l]);
    end
  end

  // Step registers. The reciprocal quotient may be one short; the fix step corrects it
  // and saturates the result to three digits.
  always_ff @(posedge clk) begin
    for (int l = 0; l < sscr_pkg::LANES; l++) begin
      case (state)
        sscr_pkg::CV_IDLE: if (start) begin
          acc[l] <= scale_prod[l];
        end
        sscr_pkg::CV_QUOT: quo[l] <= quot_prod[l][sscr_pkg::RECIP_SHIFT +: 12];
        sscr_pkg::CV_FIX: begin
          if (quo_fixed[l] > 12'(sscr_pkg::SAT_MAX)) begin
            val[l] <= sscr_pkg::SAT_MAX;
          end else begin
            val[l] <= quo_fixed[l][9:0];
          end
        end
        sscr_pkg::CV_HUND: hund[l] <= hund_prod[l][sscr_pkg::HUND_SHIFT +: 4];
        sscr_pkg::CV_REM:  rem[l] <= 7'(val[l] - rem_prod[l]);
        sscr_pkg::CV_TENS: tens[l] <= tens_prod[l][sscr_pkg::TENS_SHIFT +: 4];
        default: ;
      endcase
    end
  end

  // Digits are complete during the last step.
  always_comb begin
    res.done = (state == sscr_pkg::CV_ONES);
    for (int l = 0; l < sscr_pkg::LANES; l++) begin
      res.bcd[l][0] = hund[l];
      res.bcd[l][1] = tens[l];
      res.bcd[l][2] = ones[l];
    end
  end

endmodule

// ----- rtl/sscr_front.sv -----
// Front part: accepts input transactions, gathers command lines, keeps the mode and the
// reading digits, and posts reply jobs. Depends on sscr_pkg, sscr_in_if and sscr_conv.
module sscr_front (
  input  logic              clk,
  input  logic              rst,
  sscr_in_if.sink           item,
  output logic              push,
  output sscr_pkg::job_t    push_job,
  input  sscr_pkg::q_stat_t q_stat
);

  logic [7:0]                  command_chars [sscr_pkg::COMMAND_DEPTH];
  logic [sscr_pkg::CNT_W-1:0]  char_count, char_count_next;
  logic                        continuous_mode, continuous_mode_next;
  sscr_pkg::digits_t           temperature_digits, voltage_digits;
  logic [0:7][7:0]             line_word;
  logic                        accept, byte_ok, is_lf, buf_space;
  logic                        hit_temp, hit_pot, hit_on, hit_off;
  logic                        conv_busy, conv_start;
  sscr_pkg::conv_res_t         conv_res;

  // A reading holds off further transactions until its digits are stored.
  assign item.ready = !conv_busy && !q_stat.full;
  assign accept     = item.valid && item.ready;
  assign byte_ok    = accept && (item.operation == sscr_pkg::OP_BYTE) &&
                      !item.frame_error && !item.overrun_error;
  assign is_lf      = (item.rx_byte == sscr_pkg::LINE_FEED);
  assign buf_space  = (char_count < sscr_pkg::CNT_W'(sscr_pkg::COMMAND_DEPTH));
  assign conv_start = accept && (item.operation == sscr_pkg::OP_READ);

  sscr_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .start       (conv_start),
    .temp_sample (item.temp_sample),
    .pot_sample  (item.pot_sample),
    .busy        (conv_busy),
    .res         (conv_res)
  );

  // Command line store; characters past the end of the buffer are dropped.
  always_ff @(posedge clk) begin
    if (byte_ok && !is_lf && buf_space) begin
      command_chars[char_count[sscr_pkg::IDX_W-1:0]] <= item.rx_byte;
    end
  end

  // Compare the stored line against the command words.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      line_word[i] = command_chars[i];
    end
    hit_temp = (char_count == sscr_pkg::LEN_TEMP) && (line_word[0:3] == sscr_pkg::WORD_TEMP);
    hit_pot  = (char_count == sscr_pkg::LEN_POT)  && (line_word[0:2] == sscr_pkg::WORD_POT);
    hit_on   = (char_count == sscr_pkg::LEN_ON)   && (line_word[0:6] == sscr_pkg::WORD_ON);
    hit_off  = (char_count == sscr_pkg::LEN_OFF)  && (line_word[0:7] == sscr_pkg::WORD_OFF);
  end

  // Line count and mode.
  always_comb begin
    char_count_next      = char_count;
    continuous_mode_next = continuous_mode;
    if (byte_ok) begin
      if (!is_lf) begin
        if (buf_space) char_count_next = char_count + sscr_pkg::CNT_W'(1);
      end else begin
        char_count_next = '0;
        if (hit_on) continuous_mode_next = 1'b1;
        if (hit_off) continuous_mode_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= '0;
      continuous_mode <= 1'b0;
    end else begin
      char_count      <= char_count_next;
      continuous_mode <= continuous_mode_next;
    end
  end

  // Reading digits, shown as 'X' until the first conversion completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_digits <= {3{sscr_pkg::NO_DIGIT}};
      voltage_digits     <= {3{sscr_pkg::NO_DIGIT}};
    end else if (conv_res.done) begin
      for (int i = 0; i < 3; i++) begin
        temperature_digits[i] <= sscr_pkg::ASCII_ZERO +
                                 8'(conv_res.bcd[sscr_pkg::LANE_TEMP][i]);
        voltage_digits[i]     <= sscr_pkg::ASCII_ZERO +
                                 8'(conv_res.bcd[sscr_pkg::LANE_POT][i]);
      end
    end
  end

  // Reply jobs carry a copy of the digits as they stand now.
  always_comb begin
    push = (byte_ok && is_lf && (hit_temp || hit_pot)) ||
           (accept && (item.operation == sscr_pkg::OP_TICK) && continuous_mode);
    if (item.operation == sscr_pkg::OP_TICK) begin
      push_job.kind = sscr_pkg::JOB_TICK;
    end else if (hit_temp) begin
      push_job.kind = sscr_pkg::JOB_TEMP;
    end else begin
      push_job.kind = sscr_pkg::JOB_POT;
    end
    push_job.temp = temperature_digits;
    push_job.volt = voltage_digits;
  end

endmodule

// ----- rtl/sscr_queue.sv -----
// Short job queue between the front and back parts.
// Depends on sscr_pkg.
module sscr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sscr_pkg::job_t    push_job,
  input  logic              pop,
  output sscr_pkg::job_t    head,
  output sscr_pkg::q_stat_t stat
);

  sscr_pkg::job_t                slots [sscr_pkg::Q_DEPTH];
  logic [sscr_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [sscr_pkg::QCNT_W-1:0]   count;

  function automatic logic [sscr_pkg::QPTR_W-1:0] ptr_inc(
    input logic [sscr_pkg::QPTR_W-1:0] p
  );
    if (p == sscr_pkg::QPTR_W'(sscr_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + sscr_pkg::QPTR_W'(1);
  endfunction

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + sscr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sscr_pkg::QCNT_W'(1);
      end
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == sscr_pkg::QCNT_W'(sscr_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- rtl/sscr_back.sv -----
// Back part: takes one job at a time from the queue and sends its reply bytes through
// a registered output stage. Depends on sscr_pkg and sscr_out_if.
module sscr_back (
  input  logic              clk,
  input  logic              rst,
  input  sscr_pkg::job_t    head,
  input  sscr_pkg::q_stat_t q_stat,
  output logic              pop,
  sscr_out_if.source        reply
);

  // Positions in the full report "T=DD.DC\nPT=D.DDV\n"; shorter replies are slices of it.
  localparam logic [4:0] POS_TICK_FIRST = 5'd0;
  localparam logic [4:0] POS_TEMP_FIRST = 5'd2;
  localparam logic [4:0] POS_TEMP_LAST  = 5'd7;
  localparam logic [4:0] POS_POT_FIRST  = 5'd11;
  localparam logic [4:0] POS_POT_LAST   = 5'd16;

  sscr_pkg::back_state_t state, state_next;
  sscr_pkg::job_t        job;
  logic [4:0]            pos, end_pos;
  logic                  slot_free, send;

  function automatic logic [7:0] byte_at(input logic [4:0] p, input sscr_pkg::job_t j);
    logic [7:0] b;
    case (p)
      5'd0:    b = "T";
      5'd1:    b = "=";
      5'd2:    b = j.temp[0];
      5'd3:    b = j.temp[1];
      5'd4:    b = ".";
      5'd5:    b = j.temp[2];
      5'd6:    b = "C";
      5'd7:    b = sscr_pkg::LINE_FEED;
      5'd8:    b = "P";
      5'd9:    b = "T";
      5'd10:   b = "=";
      5'd11:   b = j.volt[0];
      5'd12:   b = ".";
      5'd13:   b = j.volt[1];
      5'd14:   b = j.volt[2];
      5'd15:   b = "V";
      default: b = sscr_pkg::LINE_FEED;
    endcase
    return b;
  endfunction

  assign slot_free = !reply.valid || reply.ready;
  assign send      = (state == sscr_pkg::BK_SEND) && slot_free;

  // Job fetch and end of run.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      sscr_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = sscr_pkg::BK_SEND;
        end
      end
      sscr_pkg::BK_SEND: begin
        if (slot_free && (pos == end_pos)) state_next = sscr_pkg::BK_IDLE;
      end
      default: state_next = sscr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job registers and byte position.
  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
      unique case (head.kind)
        sscr_pkg::JOB_TEMP: begin
          pos     <= POS_TEMP_FIRST;
          end_pos <= POS_TEMP_LAST;
        end
        sscr_pkg::JOB_POT: begin
          pos     <= POS_POT_FIRST;
          end_pos <= POS_POT_LAST;
        end
        default: begin
          pos     <= POS_TICK_FIRST;
          end_pos <= POS_POT_LAST;
        end
      endcase
    end else if (send) begin
      pos <= pos + 5'd1;
    end
  end

  // Output register; a byte waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply.valid <= 1'b0;
    end else if (send) begin
      reply.valid <= 1'b1;
    end else if (reply.ready) begin
      reply.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      reply.tx_byte <= byte_at(pos, job);
      reply.last    <= (pos == end_pos);
    end
  end

endmodule

// ----- rtl/serial_sensor_command_responder_top.sv -----
// Serial sensor command responder, top level.
// Depends on sscr_pkg, sscr_in_if, sscr_out_if, sscr_front, sscr_queue and sscr_back.
//
// Usage:
//   item  : input transactions (valid/ready). operation selects a received serial
//           byte, a new pair of sensor readings or a report tick.
//   reply : output transactions (valid/ready), one ASCII byte each; last marks the
//           final byte of a reply.
// Timing:
//   A reading pair is converted by a six-step sequencer (one multiplication per
//   step), so ready drops while it runs after a reading is accepted; the new digits
//   apply to later replies. Replies are queued as jobs (two deep) and sent one byte
//   per cycle while the receiver keeps ready high: six bytes for a single reading,
//   seventeen for a report tick, with an idle state between jobs to fetch the next
//   one. After the line feed, a reply passes the queue slot, the job register and
//   the output register. When the receiver stalls, the byte is held in the output
//   register; once the job queue fills, ready drops until the receiver drains it.
// Reset (synchronous, active high) empties the queue and output, clears the line
// buffer and continuous mode, and sets all reading digits to 'X'.
module serial_sensor_command_responder_top (
  input  logic        clk,
  input  logic        rst,
  sscr_in_if.sink     item,
  sscr_out_if.source  reply
);

  logic              push, pop;
  sscr_pkg::job_t    push_job, head;
  sscr_pkg::q_stat_t q_stat;

  sscr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .push     (push),
    .push_job (push_job),
    .q_stat   (q_stat)
  );

  sscr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sscr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .reply  (reply)
  );

  // The front never posts a job into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job posted into a full queue");

  // The back never fetches from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job fetched from an empty queue");

  // A reading holds off the next transaction while it is converted.
  a_read_stalls: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.operation == sscr_pkg::OP_READ)) |=> !item.ready)
    else $error("transaction accepted during a conversion");

  // Every reply ends in a line feed.
  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    (reply.valid && reply.last) |-> (reply.tx_byte == sscr_pkg::LINE_FEED))
    else $error("reply does not end in a line feed");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the serial sensor command responder.
// Depends on sscr_pkg, sscr_in_if, sscr_out_if and serial_sensor_command_responder_top.
// A scoreboard class predicts every reply byte for directed and random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Command that clears continuous mode.
  localparam string MODE_STOP_CMD = {"CONT_", "OFF"};

  localparam int RANDOM_ITEMS = 290;
  localparam int PHASES = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        frame_error;
    logic        overrun_error;
    logic [11:0] temp_sample;
    logic [11:0] pot_sample;
  } sensor_item_t;

  // Predicts the reply bytes of the block and checks the bytes that it sends.
  class reply_scoreboard;
    typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
    } reply_byte_t;

    reply_byte_t       expected_q[$];
    logic [7:0]        line_q[$];
    bit                streaming;
    sscr_pkg::digits_t temp_digits;
    sscr_pkg::digits_t volt_digits;
    int                errors;
    int                items_seen;
    int                bytes_checked;
    int                lines_ended;
    int                reports_sent;

    function new();
      streaming = 1'b0;
      temp_digits = {3{sscr_pkg::NO_DIGIT}};
      volt_digits = {3{sscr_pkg::NO_DIGIT}};
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_byte(logic [7:0] c);
      reply_byte_t b;
      b.tx_byte = c;
      b.last = 1'b0;
      expected_q.push_back(b);
    endfunction

    // Value in tenths or hundredths, saturated, as three ASCII digits.
    function sscr_pkg::digits_t to_ascii(int unsigned v);
      sscr_pkg::digits_t d;
      if (v > 999) v = 999;
      d[0] = 8'(sscr_pkg::ASCII_ZERO + v / 100);
      d[1] = 8'(sscr_pkg::ASCII_ZERO + (v / 10) % 10);
      d[2] = 8'(sscr_pkg::ASCII_ZERO + v % 10);
      return d;
    endfunction

    // The word is packed with its first character in the top byte of its length.
    function bit line_is(logic [63:0] word, int len);
      int i;
      if (line_q.size() != len) return 1'b0;
      for (i = 0; i < len; i++) begin
        if (line_q[i] != word[8 * (len - 1 - i) +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void queue_temperature(bit labelled);
      if (labelled) begin
        push_byte("T");
        push_byte("=");
      end
      push_byte(temp_digits[0]);
      push_byte(temp_digits[1]);
      push_byte(".");
      push_byte(temp_digits[2]);
      push_byte("C");
      push_byte(sscr_pkg::LINE_FEED);
    endfunction

    function void queue_voltage(bit labelled);
      if (labelled) begin
        push_byte("P");
        push_byte("T");
        push_byte("=");
      end
      push_byte(volt_digits[0]);
      push_byte(".");
      push_byte(volt_digits[1]);
      push_byte(volt_digits[2]);
      push_byte("V");
      push_byte(sscr_pkg::LINE_FEED);
    endfunction

    // Notes one accepted input transaction and queues the reply bytes it causes.
    function void note_item(sensor_item_t it);
      int queued_at_start;
      int unsigned tenths;
      int unsigned hundredths;
      queued_at_start = expected_q.size();
      items_seen++;
      case (it.operation)
        sscr_pkg::OP_BYTE: begin
          // Bytes with a framing or overrun error are dropped without trace.
          if (!it.frame_error && !it.overrun_error) begin
            if (it.rx_byte != sscr_pkg::LINE_FEED) begin
              if (line_q.size() < sscr_pkg::COMMAND_DEPTH) line_q.push_back(it.rx_byte);
            end else begin
              lines_ended++;
              if (line_is(64'(sscr_pkg::WORD_TEMP), sscr_pkg::LEN_TEMP)) begin
                queue_temperature(1'b0);
              end else if (line_is(64'(sscr_pkg::WORD_POT), sscr_pkg::LEN_POT)) begin
                queue_voltage(1'b0);
              end else if (line_is(64'(sscr_pkg::WORD_ON), sscr_pkg::LEN_ON)) begin
                streaming = 1'b1;
              end else if (line_is(sscr_pkg::WORD_OFF, sscr_pkg::LEN_OFF)) begin
                streaming = 1'b0;
              end
              line_q.delete();
            end
          end
        end
        sscr_pkg::OP_READ: begin
          tenths = (int'(it.temp_sample) * 806) / 1000;
          hundredths = (int'(it.pot_sample) * 806 + 5000) / 10000;
          temp_digits = to_ascii(tenths);
          volt_digits = to_ascii(hundredths);
        end
        sscr_pkg::OP_TICK: begin
          if (streaming) begin
            reports_sent++;
            queue_temperature(1'b1);
            queue_voltage(1'b1);
          end
        end
        default: begin
        end
      endcase
      if (expected_q.size() > queued_at_start) begin
        expected_q[expected_q.size() - 1].last = 1'b1;
      end
    endfunction

    // Compares one reply transaction with the oldest expected byte.
    function void check_reply(logic [7:0] tx_byte, logic last);
      reply_byte_t exp_b;
      bytes_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected reply: tx_byte %h last %b", tx_byte, last);
        errors++;
        return;
      end
      exp_b = expected_q.pop_front();
      if (tx_byte !== exp_b.tx_byte) begin
        $error("tx_byte: expected %h, actual %h", exp_b.tx_byte, tx_byte);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last: expected %b, actual %b", exp_b.last, last);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected reply bytes never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  sscr_in_if  item_ch ();
  sscr_out_if reply_ch ();

  reply_scoreboard sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;

  serial_sensor_command_responder_top dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .reply (reply_ch)
  );

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Accepted input transactions feed the predictor.
  always @(posedge clk) begin
    sensor_item_t seen;
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen.operation = item_ch.operation;
      seen.rx_byte = item_ch.rx_byte;
      seen.frame_error = item_ch.frame_error;
      seen.overrun_error = item_ch.overrun_error;
      seen.temp_sample = item_ch.temp_sample;
      seen.pot_sample = item_ch.pot_sample;
      sb.note_item(seen);
    end
  end

  // Accepted reply transactions are checked.
  always @(posedge clk) begin
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      sb.check_reply(reply_ch.tx_byte, reply_ch.last);
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length(bit allow);
    int r;
    if (!allow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: random stalls, and one long hold-off on request.
  initial begin : receiver
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        reply_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = idle_length(!quiet);
        if (stall == 0) begin
          reply_ch.ready <= 1'b1;
        end else begin
          reply_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Random content for the fields that an operation does not use.
  function automatic sensor_item_t blank_item(logic [1:0] op);
    sensor_item_t it;
    it.operation = op;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.frame_error = 1'($urandom_range(0, 1));
    it.overrun_error = 1'($urandom_range(0, 1));
    it.temp_sample = 12'($urandom_range(0, 4095));
    it.pot_sample = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  // Offers one transaction and waits for it to be taken, then idles at random.
  task automatic send_item(sensor_item_t it);
    int gap;
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.operation <= it.operation;
    item_ch.rx_byte <= it.rx_byte;
    item_ch.frame_error <= it.frame_error;
    item_ch.overrun_error <= it.overrun_error;
    item_ch.temp_sample <= it.temp_sample;
    item_ch.pot_sample <= it.pot_sample;
    do @(posedge clk); while (!item_ch.ready);
    if (it.operation != OP_IGNORED) items_sent++;
    gap = idle_length(!quiet);
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_char(logic [7:0] c);
    sensor_item_t it;
    it = blank_item(sscr_pkg::OP_BYTE);
    it.rx_byte = c;
    it.frame_error = 1'b0;
    it.overrun_error = 1'b0;
    send_item(it);
  endtask

  // A byte with a framing error, an overrun or both.
  task automatic send_damaged(logic [7:0] c);
    sensor_item_t it;
    logic [1:0] flags;
    flags = 2'($urandom_range(1, 3));
    it = blank_item(sscr_pkg::OP_BYTE);
    it.rx_byte = c;
    it.frame_error = flags[0];
    it.overrun_error = flags[1];
    send_item(it);
  endtask

  // A command line ended by LF; noisy lines carry damaged bytes in between.
  task automatic send_line(string s, bit noisy);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_damaged(8'($urandom_range(0, 255)));
      send_char(s[i]);
    end
    send_char(sscr_pkg::LINE_FEED);
  endtask

  task automatic send_reading(logic [11:0] t, logic [11:0] p);
    sensor_item_t it;
    it = blank_item(sscr_pkg::OP_READ);
    it.temp_sample = t;
    it.pot_sample = p;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(blank_item(sscr_pkg::OP_TICK));
  endtask

  // Stops offering and waits until every expected reply has come, then settles.
  task automatic drain_wait();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'd1240;
      3: return 12'd1241;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic string pick_command();
    case ($urandom_range(0, 3))
      0: return "TEMP";
      1: return "POT";
      2: return "CONT_ON";
      default: return MODE_STOP_CMD;
    endcase
  endfunction

  // One step of random traffic, weighted towards well-formed commands.
  task automatic random_action();
    int r;
    int len;
    int i;
    logic [7:0] c;
    string word;
    r = $urandom_range(0, 99);
    if (r < 20) send_line("TEMP", 1'b1);
    else if (r < 35) send_line("POT", 1'b1);
    else if (r < 42) send_line("CONT_ON", 1'b1);
    else if (r < 46) send_line(MODE_STOP_CMD, 1'b1);
    else if (r < 64) send_tick();
    else if (r < 76) send_reading(pick_sample(), pick_sample());
    else if (r < 82) begin
      // Random characters, sometimes more than the buffer holds.
      len = $urandom_range(0, 13);
      for (i = 0; i < len; i++) begin
        c = 8'($urandom_range(0, 255));
        if (c == sscr_pkg::LINE_FEED) c = c + 8'd1;
        send_char(c);
      end
      send_char(sscr_pkg::LINE_FEED);
    end else if (r < 87) begin
      // Near misses: a command cut short or with a character too many.
      word = pick_command();
      if ($urandom_range(0, 1)) send_line(word.substr(0, word.len() - 2), 1'b0);
      else send_line({word, "_"}, 1'b0);
    end else if (r < 92) send_damaged(8'($urandom_range(0, 255)));
    else if (r < 95) send_item(blank_item(OP_IGNORED));
    else send_char(sscr_pkg::LINE_FEED);
  endtask

  initial begin : stimulus
    int phase;
    int start_items;
    int i;
    sb = new();
    item_ch.valid = 1'b0;
    item_ch.operation = sscr_pkg::OP_BYTE;
    item_ch.rx_byte = 8'h00;
    item_ch.frame_error = 1'b0;
    item_ch.overrun_error = 1'b0;
    item_ch.temp_sample = 12'h000;
    item_ch.pot_sample = 12'h000;
    reply_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: tick outside continuous mode, and digits before any reading.
    send_tick();
    send_line("POT", 1'b0);
    // Saturated temperature and the largest voltage.
    send_reading(12'hFFF, 12'hFFF);
    send_line("TEMP", 1'b0);
    // Damaged bytes inside a mode command are dropped.
    send_char("C");
    send_damaged(8'hFF);
    send_char("O");
    send_damaged(8'h00);
    send_damaged(sscr_pkg::LINE_FEED);
    send_line("NT_ON", 1'b0);
    send_tick();
    send_reading(12'h000, 12'h000);
    send_tick();
    send_item(blank_item(OP_IGNORED));
    // Overflowing line, then an empty line.
    send_line({MODE_STOP_CMD, "XYZ"}, 1'b0);
    send_char(sscr_pkg::LINE_FEED);
    send_tick();
    send_line(MODE_STOP_CMD, 1'b0);
    send_tick();
    drain_wait();

    // Long receiver hold-off while ticks keep coming, so the input stalls.
    send_line("CONT_ON", 1'b0);
    drain_wait();
    hold_req = 1'b1;
    quiet = 1'b1;
    for (i = 0; i < 10; i++) send_tick();
    quiet = 1'b0;
    drain_wait();

    // Random traffic in phases; one phase runs without any idling.
    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase == 2);
      start_items = items_sent;
      while (items_sent - start_items < RANDOM_ITEMS / PHASES) random_action();
      drain_wait();
    end
    quiet = 1'b0;

    sb.report_leftovers();
    $display("tb: %0d input transactions, %0d reply bytes checked, %0d lines ended,",
             sb.items_seen, sb.bytes_checked, sb.lines_ended);
    $display("tb: %0d streamed reports, %0d mismatches", sb.reports_sent, sb.errors);
    if (sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/sscr_pkg.sv
rtl/sscr_in_if.sv
rtl/sscr_out_if.sv
rtl/sscr_conv.sv
rtl/sscr_front.sv
rtl/sscr_queue.sv
rtl/sscr_back.sv
rtl/serial_sensor_command_responder_top.sv
test/tb.sv
